// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; the user must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define STM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stm check failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define STM_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error("stm check failed");

`endif

// File: sv/stm_pkg.sv
// Shared types and constants of the template matcher.
// Depends on nothing.
package stm_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned SQ_W     = 16;
  localparam int unsigned SSD_W    = 22;
  localparam int unsigned CNT_W    = 20;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned WS_W     = 4;
  localparam int unsigned TIDX_W   = 6;
  localparam int unsigned TMPL_N   = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic CMD_TMPL  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_WINDOW_SIZE   = 2'd2,
    CFG_SSD_THRESHOLD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic shift;
    logic capture;
  } cell_ctrl_t;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] addr;
  } lb_wr_t;

endpackage

// File: sv/ssd_template_match.sv
// Streaming sum-of-squared-differences template matcher, top level.
// Depends on stm_pkg, stm_line_buf and stm_cell.
//
// The block takes one item per clock cycle, template load or pixel, and a
// result passes stage 1 to 4 registers and the output register. The rate
// is set by the column history memory, which is read and written once per
// pixel, and by the window cells, which shift one column per pixel and
// each square one difference. The squared differences are summed per row,
// then across rows in registered stages. A stalled result holds the input.
module ssd_template_match #(
  parameter int unsigned MAX_WINDOW = 8,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [stm_pkg::SSD_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [stm_pkg::PIX_W-1:0]          pixel_i,
  input  logic [stm_pkg::TIDX_W-1:0]         tmpl_index_i,
  input  logic [stm_pkg::PIX_W-1:0]          tmpl_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [stm_pkg::COORD_W-1:0]        match_row_o,
  output logic [stm_pkg::COORD_W-1:0]        match_col_o,
  output logic [stm_pkg::SSD_W-1:0]          ssd_value_o,
  output logic [stm_pkg::CNT_W-1:0]          match_index_o
);

  localparam int unsigned WC        = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;
  localparam int unsigned WIDTH_CAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned LD        = (WC > 1) ? WC - 1 : 1;
  localparam int unsigned RS_W      = stm_pkg::SQ_W + $clog2(WC);
  localparam int unsigned PW        = stm_pkg::PIX_W;
  localparam int unsigned CW        = stm_pkg::COORD_W;
  localparam int unsigned DW        = stm_pkg::DIM_W;

  // Configuration registers.
  logic [DW-1:0]               fw_q, fh_q;
  logic [stm_pkg::WS_W-1:0]    ws_q;
  logic [stm_pkg::SSD_W-1:0]   thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= DW'(640);
      fh_q  <= DW'(480);
      ws_q  <= stm_pkg::WS_W'(4);
      thr_q <= stm_pkg::SSD_W'(20);
    end else if (cfg_valid_i) begin
      case (stm_pkg::cfg_idx_e'(cfg_index_i))
        stm_pkg::CFG_FRAME_WIDTH:   fw_q  <= cfg_data_i[DW-1:0];
        stm_pkg::CFG_FRAME_HEIGHT:  fh_q  <= cfg_data_i[DW-1:0];
        stm_pkg::CFG_WINDOW_SIZE:   ws_q  <= cfg_data_i[stm_pkg::WS_W-1:0];
        stm_pkg::CFG_SSD_THRESHOLD: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DW-1:0]            w, h;
  logic [stm_pkg::WS_W-1:0] s;

  assign w = (fw_q == '0) ? DW'(1) : ((fw_q > DW'(WIDTH_CAP)) ? DW'(WIDTH_CAP) : fw_q);
  assign h = (fh_q == '0) ? DW'(1) : ((fh_q > DW'(1024)) ? DW'(1024) : fh_q);
  assign s = (ws_q == '0) ? stm_pkg::WS_W'(1)
           : ((ws_q > stm_pkg::WS_W'(WC)) ? stm_pkg::WS_W'(WC) : ws_q);

  // Pipeline advance.
  logic en, accept, pix_acc;
  logic ov_q;

  assign en         = !ov_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign pix_acc    = accept && (cmd_i == stm_pkg::CMD_PIXEL);

  // Stage 0: position counters.
  logic [CW-1:0] col_q, row_q, c0, r0, tr0, tc0;
  logic [DW-1:0] rw, cn, rn;
  logic          clr_pend_q, col_wrap, clr0, chk0;

  always_comb begin
    col_wrap = {1'b0, col_q} >= w;
    c0       = col_wrap ? '0 : col_q;
    rw       = {1'b0, row_q} + (col_wrap ? DW'(1) : DW'(0));
    clr0     = clr_pend_q;
    if (rw >= h) begin
      r0   = '0;
      clr0 = 1'b1;
    end else begin
      r0 = rw[CW-1:0];
    end
    cn   = {1'b0, c0} + DW'(1);
    rn   = {1'b0, r0} + DW'(1);
    chk0 = (rn >= DW'(s)) && (cn >= DW'(s));
    tr0  = CW'(rn - DW'(s));
    tc0  = CW'(cn - DW'(s));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      clr_pend_q <= 1'b0;
    end else if (pix_acc) begin
      if (cn >= w) begin
        col_q <= '0;
        if (rn >= h) begin
          row_q      <= '0;
          clr_pend_q <= 1'b1;
        end else begin
          row_q      <= rn[CW-1:0];
          clr_pend_q <= 1'b0;
        end
      end else begin
        col_q      <= cn[CW-1:0];
        row_q      <= r0;
        clr_pend_q <= 1'b0;
      end
    end
  end

  // Stage 1 registers.
  logic                        v1_q, cmd1_q, chk1_q, clr1_q;
  logic [PW-1:0]               pix1_q, tval1_q;
  logic [stm_pkg::TIDX_W-1:0]  tidx1_q;
  logic [CW-1:0]               c1_q, tr1_q, tc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= cmd_i;
      pix1_q  <= pixel_i;
      tidx1_q <= tmpl_index_i;
      tval1_q <= tmpl_value_i;
      c1_q    <= c0;
      chk1_q  <= chk0;
      tr1_q   <= tr0;
      tc1_q   <= tc0;
      clr1_q  <= clr0;
    end
  end

  logic            pix1, tmpl1;
  logic [LD*PW-1:0] rd_data, wr_data;
  logic [PW-1:0]    vec [WC];
  stm_pkg::lb_wr_t  lb_wr;

  assign pix1  = v1_q && (cmd1_q == stm_pkg::CMD_PIXEL);
  assign tmpl1 = v1_q && (cmd1_q == stm_pkg::CMD_TMPL);

  always_comb begin
    wr_data        = rd_data;
    wr_data[PW-1:0] = pix1_q;
    for (int j = 1; j < LD; j++) begin
      wr_data[j*PW +: PW] = rd_data[(j-1)*PW +: PW];
    end
    vec[0] = pix1_q;
    for (int a = 1; a < WC; a++) begin
      vec[a] = rd_data[(a-1)*PW +: PW];
    end
  end

  assign lb_wr.en   = en && pix1;
  assign lb_wr.addr = c1_q;

  stm_line_buf #(
    .DEPTH (WIDTH_CAP),
    .LANES (LD)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (en),
    .rd_addr_i (c0),
    .wr_i      (lb_wr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // Template store, written in order with the pixels in flight.
  logic [PW-1:0] tmpl_q [stm_pkg::TMPL_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < stm_pkg::TMPL_N; i++) begin
        tmpl_q[i] <= '0;
      end
    end else if (en && tmpl1) begin
      tmpl_q[tidx1_q] <= tval1_q;
    end
  end

  // Stage 2 registers.
  logic          v2_q, chk2_q, clr2_q;
  logic [CW-1:0] tr2_q, tc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= pix1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chk2_q <= chk1_q;
      clr2_q <= clr1_q;
      tr2_q  <= tr1_q;
      tc2_q  <= tc1_q;
    end
  end

  // Grid of window cells, one per window row and column.
  stm_pkg::cell_ctrl_t        cell_ctrl;
  logic [PW-1:0]              cpix [WC][WC];
  logic [stm_pkg::SQ_W-1:0]   sq   [WC][WC];

  assign cell_ctrl.shift   = en && pix1;
  assign cell_ctrl.capture = en;

  for (genvar a = 0; a < WC; a++) begin : g_row
    for (genvar b = 0; b < WC; b++) begin : g_col
      logic [stm_pkg::WS_W-1:0] k, m;
      logic                     act;
      logic [PW-1:0]            tsel, pin;

      assign act  = (stm_pkg::WS_W'(a) < s) && (stm_pkg::WS_W'(b) < s);
      assign k    = s - stm_pkg::WS_W'(a + 1);
      assign m    = s - stm_pkg::WS_W'(b + 1);
      assign tsel = tmpl_q[{k[2:0], m[2:0]}];

      if (b == 0) begin : g_first
        assign pin = vec[a];
      end else begin : g_next
        assign pin = cpix[a][b-1];
      end

      stm_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (cell_ctrl),
        .pix_i    (pin),
        .tmpl_i   (tsel),
        .active_i (act),
        .pix_o    (cpix[a][b]),
        .sq_o     (sq[a][b])
      );
    end
  end

  // Stage 3: squares registered in the cells, row sums follow.
  logic          v3_q, chk3_q, clr3_q;
  logic [CW-1:0] tr3_q, tc3_q;
  logic [RS_W-1:0] rs_d [WC];
  logic [RS_W-1:0] rs_q [WC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chk3_q <= chk2_q;
      clr3_q <= clr2_q;
      tr3_q  <= tr2_q;
      tc3_q  <= tc2_q;
    end
  end

  always_comb begin
    for (int a = 0; a < WC; a++) begin
      rs_d[a] = '0;
      for (int b = 0; b < WC; b++) begin
        rs_d[a] = rs_d[a] + RS_W'(sq[a][b]);
      end
    end
  end

  // Stage 4: total, compare and match count.
  logic          v4_q, chk4_q, clr4_q;
  logic [CW-1:0] tr4_q, tc4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chk4_q <= chk3_q;
      clr4_q <= clr3_q;
      tr4_q  <= tr3_q;
      tc4_q  <= tc3_q;
      for (int a = 0; a < WC; a++) begin
        rs_q[a] <= rs_d[a];
      end
    end
  end

  logic [stm_pkg::SSD_W-1:0] total;
  logic [stm_pkg::CNT_W-1:0] cnt_q, cnt_eff;
  logic                      hit;

  always_comb begin
    total = '0;
    for (int a = 0; a < WC; a++) begin
      total = total + stm_pkg::SSD_W'(rs_q[a]);
    end
  end

  assign hit     = v4_q && chk4_q && (total < thr_q);
  assign cnt_eff = clr4_q ? '0 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else if (en) begin
      ov_q <= hit;
      if (v4_q) begin
        if (hit && (cnt_eff != stm_pkg::CNT_MAX)) begin
          cnt_q <= cnt_eff + stm_pkg::CNT_W'(1);
        end else begin
          cnt_q <= cnt_eff;
        end
      end
    end
  end

  logic [CW-1:0]             orow_q, ocol_q;
  logic [stm_pkg::SSD_W-1:0] ossd_q;
  logic [stm_pkg::CNT_W-1:0] oidx_q;

  always_ff @(posedge clk_i) begin
    if (en && hit) begin
      orow_q <= tr4_q;
      ocol_q <= tc4_q;
      ossd_q <= total;
      oidx_q <= cnt_eff;
    end
  end

  assign out_valid_o   = ov_q;
  assign match_row_o   = orow_q;
  assign match_col_o   = ocol_q;
  assign ssd_value_o   = ossd_q;
  assign match_index_o = oidx_q;

endmodule

// File: sv/stm_cell.sv
// One window cell: holds a pixel, passes it to its right neighbor and
// registers its squared difference against a template entry. Uses stm_pkg.
module stm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stm_pkg::cell_ctrl_t         ctrl_i,
  input  logic [stm_pkg::PIX_W-1:0]   pix_i,
  input  logic [stm_pkg::PIX_W-1:0]   tmpl_i,
  input  logic                        active_i,
  output logic [stm_pkg::PIX_W-1:0]   pix_o,
  output logic [stm_pkg::SQ_W-1:0]    sq_o
);

  logic [stm_pkg::PIX_W-1:0] pix_q;
  logic [stm_pkg::PIX_W-1:0] diff;
  logic [stm_pkg::SQ_W-1:0]  sq_d, sq_q;

  assign diff = (pix_q >= tmpl_i) ? (pix_q - tmpl_i) : (tmpl_i - pix_q);
  assign sq_d = active_i ? (stm_pkg::SQ_W'(diff) * stm_pkg::SQ_W'(diff)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (ctrl_i.shift) begin
      pix_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      sq_q <= sq_d;
    end
  end

  assign pix_o = pix_q;
  assign sq_o  = sq_q;

endmodule

// File: sv/stm_line_buf.sv
// Column history memory: one word per column holding older pixels, with a
// registered read and forwarding of a same-cycle write. Uses stm_pkg.
module stm_line_buf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned LANES = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [stm_pkg::COORD_W-1:0]          rd_addr_i,
  input  stm_pkg::lb_wr_t                      wr_i,
  input  logic [LANES*stm_pkg::PIX_W-1:0]      wr_data_i,
  output logic [LANES*stm_pkg::PIX_W-1:0]      rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned DW = LANES * stm_pkg::PIX_W;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q;
  logic [DW-1:0] fwd_data_q;
  logic          fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_q      <= mem[rd_addr_i[AW-1:0]];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : mem_q;

endmodule

// File: sv/stm_checker.sv
// Port-level checks of the template matcher and their binding.
// Depends on stm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_ready_o,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [stm_pkg::COORD_W-1:0]        match_row_o,
  input logic [stm_pkg::COORD_W-1:0]        match_col_o,
  input logic [stm_pkg::SSD_W-1:0]          ssd_value_o,
  input logic [stm_pkg::CNT_W-1:0]          match_index_o
);

  `STM_ASSERT(a_stall_blocks_input, out_valid_o && !out_ready_i |-> !in_ready_o)
  `STM_ASSERT(a_ready_only_on_stall, !in_ready_o |-> out_valid_o)
  `STM_ASSERT(a_ssd_in_range, out_valid_o |-> ssd_value_o <= 22'd4161600)
  `STM_ASSERT(a_cfg_always_ready, cfg_ready_o)
  `STM_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(match_row_o) && $stable(match_col_o) && $stable(ssd_value_o) && $stable(match_index_o))

endmodule

bind ssd_template_match stm_checker u_stm_checker (.*);

// File: test/tb.sv
// Self-checking testbench for the streaming template matcher ssd_template_match.
// Depends on stm_pkg and the block's RTL; it holds its own predictor of the block
// and runs directed rows, frame edges, then random frames in three idling schemes.
module tb;

  typedef struct packed {
    logic [stm_pkg::COORD_W-1:0] row;
    logic [stm_pkg::COORD_W-1:0] col;
    logic [stm_pkg::SSD_W-1:0]   ssd;
    logic [stm_pkg::CNT_W-1:0]   idx;
  } match_t;

  typedef struct {
    bit                reg_dummy;
    bit                is_cfg;
    stm_pkg::cfg_idx_e reg_sel;
    int                data;
    logic              cmd;
    int                pix;
    int                tidx;
    int                tval;
    bit                typed;
    bit                hit;
    match_t            res;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [stm_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [stm_pkg::SSD_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          cmd_i = stm_pkg::CMD_PIXEL;
  logic [stm_pkg::PIX_W-1:0]     pixel_i = '0;
  logic [stm_pkg::TIDX_W-1:0]    tmpl_index_i = '0;
  logic [stm_pkg::PIX_W-1:0]     tmpl_value_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [stm_pkg::COORD_W-1:0]   match_row_o;
  logic [stm_pkg::COORD_W-1:0]   match_col_o;
  logic [stm_pkg::SSD_W-1:0]     ssd_value_o;
  logic [stm_pkg::CNT_W-1:0]     match_index_o;

  ssd_template_match uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Predictor state.
  logic [7:0]  tmpl_mem [64];
  logic [7:0]  col_hist [1024][8];
  logic [7:0]  win_mem [8][8];
  int unsigned cur_row, cur_col, match_cnt;
  int unsigned width_reg, height_reg, win_reg, thr_reg;

  match_t      pending_matches[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int unsigned items_sent = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit match_step(logic cmd, logic [7:0] pix, logic [5:0] ti,
                                    logic [7:0] tv, output match_t res);
    int unsigned w, h, s, r, c, sum;
    logic [7:0]  vec [8];
    int          d;
    bit          hit;
    hit = 1'b0;
    res = '0;
    if (cmd == stm_pkg::CMD_TMPL) begin
      tmpl_mem[ti] = tv;
      return 1'b0;
    end
    w = clampu(width_reg, 1, 1024);
    h = clampu(height_reg, 1, 1024);
    s = clampu(win_reg, 1, 8);
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) begin
      cur_row = 0;
      match_cnt = 0;
    end
    r = cur_row;
    c = cur_col;
    vec[0] = pix;
    for (int a = 1; a < 8; a++) vec[a] = col_hist[c][a-1];
    for (int a = 7; a >= 1; a--) col_hist[c][a] = col_hist[c][a-1];
    col_hist[c][0] = pix;
    for (int a = 0; a < 8; a++) begin
      for (int b = 7; b >= 1; b--) win_mem[a][b] = win_mem[a][b-1];
      win_mem[a][0] = vec[a];
    end
    if (r + 1 >= s && c + 1 >= s) begin
      sum = 0;
      for (int k = 0; k < s; k++) begin
        for (int m = 0; m < s; m++) begin
          d = int'(win_mem[s-1-k][s-1-m]) - int'(tmpl_mem[k*8+m]);
          sum += d * d;
        end
      end
      if (sum < thr_reg) begin
        res.row = stm_pkg::COORD_W'(r + 1 - s);
        res.col = stm_pkg::COORD_W'(c + 1 - s);
        res.ssd = stm_pkg::SSD_W'(sum);
        res.idx = stm_pkg::CNT_W'(match_cnt);
        if (match_cnt < stm_pkg::CNT_MAX) match_cnt++;
        hit = 1'b1;
      end
    end
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= h) begin
        cur_row = 0;
        match_cnt = 0;
      end
    end
    return hit;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    match_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_matches.size() == 0) begin
          report("unexpected match_row", match_row_o, -1);
        end else begin
          want = pending_matches.pop_front();
          if (match_row_o !== want.row) report("match_row", match_row_o, want.row);
          if (match_col_o !== want.col) report("match_col", match_col_o, want.col);
          if (ssd_value_o !== want.ssd) report("ssd_value", ssd_value_o, want.ssd);
          if (match_index_o !== want.idx) report("match_index", match_index_o, want.idx);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic sender_gap();
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(stm_pkg::cfg_idx_e sel, int unsigned value);
    in_valid_i <= 1'b0;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= stm_pkg::SSD_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (sel)
      stm_pkg::CFG_FRAME_WIDTH:  width_reg  = value & 32'h7FF;
      stm_pkg::CFG_FRAME_HEIGHT: height_reg = value & 32'h7FF;
      stm_pkg::CFG_WINDOW_SIZE:  win_reg    = value & 32'hF;
      default:                   thr_reg    = value & 32'h3FFFFF;
    endcase
  endtask

  // Sends one item; a typed expectation replaces the predicted one when given.
  task automatic send_item(logic cmd, int pix, int ti, int tv,
                           bit typed = 0, bit t_hit = 0, match_t t_res = '0);
    match_t res;
    bit     hit;
    sender_gap();
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    pixel_i      <= stm_pkg::PIX_W'(pix);
    tmpl_index_i <= stm_pkg::TIDX_W'(ti);
    tmpl_value_i <= stm_pkg::PIX_W'(tv);
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    hit = match_step(cmd, stm_pkg::PIX_W'(pix), stm_pkg::TIDX_W'(ti),
                     stm_pkg::PIX_W'(tv), res);
    if (typed) begin
      if (t_hit) pending_matches = {pending_matches, t_res};
    end else if (hit) begin
      pending_matches = {pending_matches, res};
    end
  endtask

  // Pixels follow the template tiled with the window period, plus noise.
  task automatic send_random();
    int unsigned s, p;
    s = clampu(win_reg, 1, 8);
    if ($urandom_range(99) < 8) begin
      send_item(stm_pkg::CMD_TMPL, $urandom_range(255), $urandom_range(63),
                $urandom_range(255));
    end else if ($urandom_range(99) < 60) begin
      p = tmpl_mem[((cur_row % s) * 8) + (cur_col % s)];
      if ($urandom_range(3) == 0) p = (p + $urandom_range(4)) & 8'hFF;
      send_item(stm_pkg::CMD_PIXEL, p, $urandom_range(63), $urandom_range(255));
    end else begin
      send_item(stm_pkg::CMD_PIXEL, $urandom_range(255), $urandom_range(63),
                $urandom_range(255));
    end
  endtask

  task automatic finish_frame();
    while (cur_row != 0 || cur_col != 0)
      send_item(stm_pkg::CMD_PIXEL, $urandom_range(255), $urandom_range(63),
                $urandom_range(255));
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned ws, int unsigned thr);
    write_reg(stm_pkg::CFG_FRAME_WIDTH, w);
    write_reg(stm_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(stm_pkg::CFG_WINDOW_SIZE, ws);
    write_reg(stm_pkg::CFG_SSD_THRESHOLD, thr);
  endtask

  function automatic row_t cfg_row(stm_pkg::cfg_idx_e sel, int value);
    row_t r;
    r = '{default: 0, reg_sel: sel, cmd: stm_pkg::CMD_PIXEL, res: '0};
    r.is_cfg = 1'b1;
    r.data = value;
    return r;
  endfunction

  function automatic row_t item_row(logic cmd, int pix, int ti, int tv,
                                    bit typed, bit hit, match_t res);
    row_t r;
    r = '{default: 0, reg_sel: stm_pkg::CFG_FRAME_WIDTH, cmd: cmd, res: res};
    r.pix = pix;
    r.tidx = ti;
    r.tval = tv;
    r.typed = typed;
    r.hit = hit;
    return r;
  endfunction

  localparam int unsigned THR_TOP = 22'h3FFFFF;
  row_t directed[];

  initial begin
    int unsigned thr, w, h, ws, phase_start;
    width_reg = 640;
    height_reg = 480;
    win_reg = 4;
    thr_reg = 20;
    cur_row = 0;
    cur_col = 0;
    match_cnt = 0;
    foreach (tmpl_mem[i]) tmpl_mem[i] = '0;
    foreach (win_mem[a, b]) win_mem[a][b] = '0;
    foreach (col_hist[a, b]) col_hist[a][b] = '0;

    directed = '{
      cfg_row(stm_pkg::CFG_FRAME_WIDTH, 0), cfg_row(stm_pkg::CFG_FRAME_HEIGHT, 0),
      cfg_row(stm_pkg::CFG_WINDOW_SIZE, 0), cfg_row(stm_pkg::CFG_SSD_THRESHOLD, THR_TOP),
      item_row(stm_pkg::CMD_PIXEL, 255, 0, 0, 1, 1, '{10'd0, 10'd0, 22'd65025, 20'd0}),
      item_row(stm_pkg::CMD_PIXEL, 0, 0, 0, 1, 1, '{10'd0, 10'd0, 22'd0, 20'd0}),
      item_row(stm_pkg::CMD_TMPL, 0, 0, 255, 1, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 255, 0, 0, 1, 1, '{10'd0, 10'd0, 22'd0, 20'd0}),
      item_row(stm_pkg::CMD_PIXEL, 0, 0, 0, 1, 1, '{10'd0, 10'd0, 22'd65025, 20'd0}),
      item_row(stm_pkg::CMD_TMPL, 0, 63, 0, 1, 0, '0),
      item_row(stm_pkg::CMD_TMPL, 0, 0, 0, 1, 0, '0),
      cfg_row(stm_pkg::CFG_SSD_THRESHOLD, 0),
      item_row(stm_pkg::CMD_PIXEL, 7, 0, 0, 1, 0, '0),
      cfg_row(stm_pkg::CFG_SSD_THRESHOLD, 1),
      item_row(stm_pkg::CMD_PIXEL, 0, 0, 0, 1, 1, '{10'd0, 10'd0, 22'd0, 20'd0}),
      cfg_row(stm_pkg::CFG_FRAME_WIDTH, 3), cfg_row(stm_pkg::CFG_FRAME_HEIGHT, 3),
      cfg_row(stm_pkg::CFG_WINDOW_SIZE, 2), cfg_row(stm_pkg::CFG_SSD_THRESHOLD, THR_TOP),
      item_row(stm_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 255, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 17, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 128, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 255, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 1, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 200, 0, 0, 0, 0, '0),
      item_row(stm_pkg::CMD_PIXEL, 77, 0, 0, 0, 0, '0)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg)
        write_reg(directed[i].reg_sel, directed[i].data);
      else
        send_item(directed[i].cmd, directed[i].pix, directed[i].tidx, directed[i].tval,
                  directed[i].typed, directed[i].hit, directed[i].res);
    end

    // Frame edges: a window larger than the frame, then a height beyond the
    // limit that is cut short in the middle of the frame, then a window as large as the frame.
    set_frame(5, 2, 15, THR_TOP);
    send_item(stm_pkg::CMD_PIXEL, 3, 0, 0);
    finish_frame();
    set_frame(1, 2047, 1, THR_TOP);
    repeat (6) send_item(stm_pkg::CMD_PIXEL, 3, 0, 0);
    write_reg(stm_pkg::CFG_FRAME_HEIGHT, 1);
    finish_frame();
    set_frame(8, 8, 8, THR_TOP);
    send_item(stm_pkg::CMD_PIXEL, 3, 0, 0);
    finish_frame();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 28 : ((phase == 1) ? 72 : 0);
      recv_idle = (phase == 0) ? 72 : ((phase == 1) ? 28 : 0);
      phase_start = items_sent;
      while (items_sent - phase_start < 300) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 10);
        ws = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
        case ($urandom_range(3))
          0: thr = THR_TOP;
          1: thr = $urandom_range(THR_TOP);
          2: thr = $urandom_range(200);
          default: thr = 0;
        endcase
        set_frame(w, h, ws, thr);
        for (int k = 0; k < 64; k++)
          if ($urandom_range(1)) send_item(stm_pkg::CMD_TMPL, 0, k, $urandom_range(255));
        for (int n = 0; n < int'(w * h * 2); n++) begin
          send_random();
          if (n == int'(w * h) && $urandom_range(4) == 0 && cur_row > 0)
            write_reg(stm_pkg::CFG_FRAME_HEIGHT, $urandom_range(1, cur_row));
        end
        finish_frame();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
